@@ hw/rtl/rhc_pkg.sv @@
// ----------------------------------------------------------------------------
// rhc_pkg: shared types for the RGB to HSV converter
// Word formats of the pixel input and result channels, plus the widths of
// the divider datapath.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int CHAN_W = 8;

  // Saturation dividend 255*delta fits in 16 bits, its divisor is max (8 bits).
  localparam int SAT_REM_W = 16;
  localparam int SAT_DIV_W = 8;

  // Hue numerator lies below 6*delta <= 1530, so 11 bits; times 255 it fits 19.
  localparam int HUE_NUM_W = 11;
  localparam int HUE_REM_W = 19;
  localparam int HUE_DIV_W = 11;

  // Both quotients are known to stay below 256.
  localparam int QUO_W = 8;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
    logic [CHAN_W-1:0] alpha_in;
  } pixel_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] hue_out;
    logic [CHAN_W-1:0] saturation_out;
    logic [CHAN_W-1:0] value_out;
    logic [CHAN_W-1:0] alpha_out;
  } pixel_out_t;

endpackage

@@ hw/rtl/rgb_to_hsv_converter.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter: 8-bit RGBA to 8-bit HSV plus alpha
// Fully pipelined converter with two restoring dividers, one quotient bit
// per stage, for saturation and hue.
// ----------------------------------------------------------------------------
// Usage:
// A pixel word is presented on in_pixel and taken at a rising edge where
// start is high and busy is low. The pipeline carries no state between
// pixels, so busy is held low and a new word may be started every cycle.
// Each result word appears on out_pixel for exactly one cycle, marked by
// out_valid. Throughput is one word per clock. The pipeline is made of
// the three front stages (min/max, operand select, scaling by 255) plus
// eight divider stages, one per quotient bit, eleven registers in all.
// Words leave in the order they entered.
// The synchronous active-low reset clears all stage valid bits, so no stale
// word can emerge after reset; data registers are not reset.
// The receiver cannot stall: a result word must be taken when out_valid is
// high, and the pipeline never holds back.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  rhc_pkg::pixel_in_t   in_pixel,
  output logic                 out_valid,
  output rhc_pkg::pixel_out_t  out_pixel
);

  localparam int NDIV = rhc_pkg::QUO_W;

  // Stage 1: channel maximum and minimum plus the hue sector flags.
  typedef struct packed {
    logic [rhc_pkg::CHAN_W-1:0] red;
    logic [rhc_pkg::CHAN_W-1:0] green;
    logic [rhc_pkg::CHAN_W-1:0] blue;
    logic [rhc_pkg::CHAN_W-1:0] alpha;
    logic [rhc_pkg::CHAN_W-1:0] max_v;
    logic [rhc_pkg::CHAN_W-1:0] min_v;
    logic                       red_max;
    logic                       green_max;
    logic                       green_lt_blue;
  } s1_t;

  // Stage 2: delta, hue numerator and both divisors.
  typedef struct packed {
    logic [rhc_pkg::CHAN_W-1:0]    alpha;
    logic [rhc_pkg::CHAN_W-1:0]    max_v;
    logic [rhc_pkg::CHAN_W-1:0]    delta;
    logic [rhc_pkg::HUE_NUM_W-1:0] hue_num;
    logic [rhc_pkg::SAT_DIV_W-1:0] sat_div;
    logic [rhc_pkg::HUE_DIV_W-1:0] hue_div;
  } s2_t;

  // Divider stages: partial remainders and quotients travel together.
  typedef struct packed {
    logic [rhc_pkg::CHAN_W-1:0]    alpha;
    logic [rhc_pkg::CHAN_W-1:0]    max_v;
    logic [rhc_pkg::SAT_REM_W-1:0] sat_rem;
    logic [rhc_pkg::SAT_DIV_W-1:0] sat_div;
    logic [rhc_pkg::QUO_W-1:0]     sat_quo;
    logic [rhc_pkg::HUE_REM_W-1:0] hue_rem;
    logic [rhc_pkg::HUE_DIV_W-1:0] hue_div;
    logic [rhc_pkg::QUO_W-1:0]     hue_quo;
  } div_t;

  logic  in_take;
  s1_t   s1_r, s1_nxt;
  logic  s1_vld_r;
  s2_t   s2_r, s2_nxt;
  logic  s2_vld_r;
  div_t  stg_r   [0:NDIV];
  div_t  stg_nxt [0:NDIV];
  logic  vld_r   [0:NDIV];

  // The pipeline never backs up, so it is always ready for a word.
  assign busy    = 1'b0;
  assign in_take = start && !busy;

  // Stage 1: compare channels. Red wins ties, then green.
  always_comb begin
    logic [rhc_pkg::CHAN_W-1:0] r, g, b;
    r = in_pixel.red_in;
    g = in_pixel.green_in;
    b = in_pixel.blue_in;
    s1_nxt.red   = r;
    s1_nxt.green = g;
    s1_nxt.blue  = b;
    s1_nxt.alpha = in_pixel.alpha_in;
    s1_nxt.red_max       = (r >= g) && (r >= b);
    s1_nxt.green_max     = !s1_nxt.red_max && (g >= b);
    s1_nxt.green_lt_blue = g < b;
    if (s1_nxt.red_max) begin
      s1_nxt.max_v = r;
    end else if (s1_nxt.green_max) begin
      s1_nxt.max_v = g;
    end else begin
      s1_nxt.max_v = b;
    end
    if ((r <= g) && (r <= b)) begin
      s1_nxt.min_v = r;
    end else if (g <= b) begin
      s1_nxt.min_v = g;
    end else begin
      s1_nxt.min_v = b;
    end
  end

  // Stage 2: the hue numerator base*delta + diff always lands in [0, 6*delta),
  // so it is formed modulo 2^11 and the wrap of a negative diff cancels out.
  always_comb begin
    logic [rhc_pkg::HUE_NUM_W-1:0] d, d2, d4, d6, r, g, b;
    d  = rhc_pkg::HUE_NUM_W'(s1_r.max_v - s1_r.min_v);
    d2 = d << 1;
    d4 = d << 2;
    d6 = d4 + d2;
    r  = rhc_pkg::HUE_NUM_W'(s1_r.red);
    g  = rhc_pkg::HUE_NUM_W'(s1_r.green);
    b  = rhc_pkg::HUE_NUM_W'(s1_r.blue);
    s2_nxt.alpha = s1_r.alpha;
    s2_nxt.max_v = s1_r.max_v;
    s2_nxt.delta = s1_r.max_v - s1_r.min_v;
    if (s1_r.red_max) begin
      s2_nxt.hue_num = s1_r.green_lt_blue ? (d6 + g - b) : (g - b);
    end else if (s1_r.green_max) begin
      s2_nxt.hue_num = d2 + b - r;
    end else begin
      s2_nxt.hue_num = d4 + r - g;
    end
    // A grey or black pixel has a zero dividend; a divisor of one then
    // yields the required zero quotient.
    s2_nxt.sat_div = (s1_r.max_v == '0) ? rhc_pkg::SAT_DIV_W'(1) : s1_r.max_v;
    s2_nxt.hue_div = (d == '0) ? rhc_pkg::HUE_DIV_W'(1) : d6;
  end

  // Stage 3 scales both dividends by 255 as x*256 - x. Divider stage k then
  // settles quotient bit NDIV-k of both divisions. Each dividend is below
  // 256 times its divisor, so eight bits suffice.
  always_comb begin
    logic [rhc_pkg::SAT_REM_W-1:0] sd, sat_sh;
    logic [rhc_pkg::HUE_REM_W-1:0] hn, hue_sh;
    sd = rhc_pkg::SAT_REM_W'(s2_r.delta);
    hn = rhc_pkg::HUE_REM_W'(s2_r.hue_num);
    stg_nxt[0].alpha   = s2_r.alpha;
    stg_nxt[0].max_v   = s2_r.max_v;
    stg_nxt[0].sat_rem = (sd << 8) - sd;
    stg_nxt[0].sat_div = s2_r.sat_div;
    stg_nxt[0].sat_quo = '0;
    stg_nxt[0].hue_rem = (hn << 8) - hn;
    stg_nxt[0].hue_div = s2_r.hue_div;
    stg_nxt[0].hue_quo = '0;
    for (int k = 1; k <= NDIV; k++) begin
      sat_sh = rhc_pkg::SAT_REM_W'(stg_r[k-1].sat_div) << (NDIV - k);
      hue_sh = rhc_pkg::HUE_REM_W'(stg_r[k-1].hue_div) << (NDIV - k);
      stg_nxt[k] = stg_r[k-1];
      if (stg_r[k-1].sat_rem >= sat_sh) begin
        stg_nxt[k].sat_rem           = stg_r[k-1].sat_rem - sat_sh;
        stg_nxt[k].sat_quo[NDIV - k] = 1'b1;
      end
      if (stg_r[k-1].hue_rem >= hue_sh) begin
        stg_nxt[k].hue_rem           = stg_r[k-1].hue_rem - hue_sh;
        stg_nxt[k].hue_quo[NDIV - k] = 1'b1;
      end
    end
  end

  // Data registers, no reset.
  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
    for (int i = 0; i <= NDIV; i++) begin
      stg_r[i] <= stg_nxt[i];
    end
  end

  // Valid bits follow their data through every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      for (int i = 0; i <= NDIV; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      s1_vld_r <= in_take;
      s2_vld_r <= s1_vld_r;
      vld_r[0] <= s2_vld_r;
      for (int i = 1; i <= NDIV; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign out_valid                = vld_r[NDIV];
  assign out_pixel.hue_out        = stg_r[NDIV].hue_quo;
  assign out_pixel.saturation_out = stg_r[NDIV].sat_quo;
  assign out_pixel.value_out      = stg_r[NDIV].max_v;
  assign out_pixel.alpha_out      = stg_r[NDIV].alpha;

  // A word in the first stage always reaches the output.
  a_pipe_flow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> ##10 out_valid)
    else $error("word lost in the pipeline");

  // Hue of a full turn never reaches 255.
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pixel.hue_out != 8'hFF)
    else $error("hue quotient out of range");

  // Black gives zero saturation.
  a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pixel.value_out == '0) |-> out_pixel.saturation_out == '0)
    else $error("nonzero saturation for black");

  // Zero saturation means a grey pixel, whose hue must be zero.
  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pixel.saturation_out == '0) |-> out_pixel.hue_out == '0)
    else $error("nonzero hue for grey");

endmodule

@@ sim/rgb_to_hsv_converter_tb.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_tb: self-checking testbench for the RGB to HSV converter
// Drives RGBA pixel words through the start/busy handshake with random idle
// bursts. A scoreboard predicts hue, saturation, value and alpha with exact
// integer floor division and compares every result word, in order, against
// the oldest prediction.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_tb;

  localparam int RANDOM_ITEMS   = 850;
  // The last stretch of random words runs back to back with no idling.
  localparam int NO_IDLE_TAIL   = 150;
  // The pipeline is eleven stages deep, and this wait outlasts it comfortably.
  localparam int DRAIN_CYCLES   = 20;
  // Longest correct quiet spell: reset, the longest idle burst plus the
  // pipeline latency. WATCHDOG_LIMIT is many times that.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 10;

  // Scoreboard: one prediction per accepted pixel word, consumed in order.
  class hsv_scoreboard;
    rhc_pkg::pixel_out_t expected_hsv[$];
    int                  errors;

    function new();
      errors = 0;
    endfunction

    // Exact integer HSV conversion with floor rounding.
    function rhc_pkg::pixel_out_t hsv_of(rhc_pkg::pixel_in_t p);
      int                  r, g, b, hi, lo, delta, num;
      rhc_pkg::pixel_out_t res;
      r  = p.red_in;
      g  = p.green_in;
      b  = p.blue_in;
      hi = (r > g) ? r : g;
      hi = (hi > b) ? hi : b;
      lo = (r < g) ? r : g;
      lo = (lo < b) ? lo : b;
      delta = hi - lo;
      res.value_out      = hi[7:0];
      res.alpha_out      = p.alpha_in;
      res.saturation_out = '0;
      res.hue_out        = '0;
      // Black has no saturation; the division by max is skipped.
      if (hi != 0) begin
        res.saturation_out = 8'((255 * delta) / hi);
      end
      // Grey has no hue. Otherwise the hue sector is chosen with red tested
      // first and green second, so ties for the maximum resolve that way.
      if (delta != 0) begin
        if (r == hi) begin
          num = g - b;
          if (g < b) begin
            num += 6 * delta;
          end
        end else if (g == hi) begin
          num = 2 * delta + (b - r);
        end else begin
          num = 4 * delta + (r - g);
        end
        if (num < 0) begin
          num = 0;
        end
        res.hue_out = 8'((255 * num) / (6 * delta));
      end
      return res;
    endfunction

    function void note_pixel(rhc_pkg::pixel_in_t p);
      expected_hsv.push_back(hsv_of(p));
    endfunction

    function void check_pixel(rhc_pkg::pixel_out_t got);
      rhc_pkg::pixel_out_t exp_word;
      if (expected_hsv.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("ERROR: unexpected result word h=%0d s=%0d v=%0d a=%0d",
                   got.hue_out, got.saturation_out, got.value_out, got.alpha_out);
        end
        return;
      end
      exp_word = expected_hsv.pop_front();
      if (got.hue_out !== exp_word.hue_out ||
          got.saturation_out !== exp_word.saturation_out ||
          got.value_out !== exp_word.value_out ||
          got.alpha_out !== exp_word.alpha_out) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("ERROR: expected h=%0d s=%0d v=%0d a=%0d, got h=%0d s=%0d v=%0d a=%0d",
                   exp_word.hue_out, exp_word.saturation_out, exp_word.value_out,
                   exp_word.alpha_out, got.hue_out, got.saturation_out,
                   got.value_out, got.alpha_out);
        end
      end
    endfunction

    function int pending();
      return expected_hsv.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  rhc_pkg::pixel_in_t  in_pixel;
  logic                out_valid;
  rhc_pkg::pixel_out_t out_pixel;

  hsv_scoreboard hsv_sb = new();
  int            quiet_cycles = 0;

  always #5 clk = ~clk;

  rgb_to_hsv_converter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_pixel  (in_pixel),
    .out_valid (out_valid),
    .out_pixel (out_pixel)
  );

  // Monitor. All handshake signals are driven with nonblocking assignments
  // at the rising edge, so reading them here sees the values that were
  // present during the cycle that this edge closes. That is exactly what
  // the block itself samples, independent of scheduling order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        hsv_sb.note_pixel(in_pixel);
      end
      if (out_valid) begin
        hsv_sb.check_pixel(out_pixel);
      end
    end
    // The watchdog only counts cycles in which no word moves either way.
    if ((rst_n && start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("rgb_to_hsv_converter verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one pixel word and returns at the edge where it was taken.
  // Start stays high on return, so a following call keeps the stream going
  // without a bubble.
  task automatic send_pixel(input rhc_pkg::pixel_in_t p);
    in_pixel <= p;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_rgba(input logic [7:0] r, g, b, a);
    rhc_pkg::pixel_in_t p;
    p.red_in   = r;
    p.green_in = g;
    p.blue_in  = b;
    p.alpha_in = a;
    send_pixel(p);
  endtask

  // Drops start for a number of cycles. The data lines carry junk meanwhile
  // to show that the block ignores them while start is low.
  task automatic idle_for(input int cycles);
    start    <= 1'b0;
    in_pixel <= rhc_pkg::pixel_in_t'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // Picks a channel value that favors the corners of the range.
  function automatic logic [7:0] edge_chan();
    case ($urandom_range(5))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd254;
      3:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Random pixels, mixed so that grey, ties for the maximum, tiny deltas
  // and range corners show up far more often than pure chance would give.
  function automatic rhc_pkg::pixel_in_t random_pixel();
    rhc_pkg::pixel_in_t p;
    int                 lvl;
    p = rhc_pkg::pixel_in_t'($urandom);
    lvl = $urandom_range(255);
    case ($urandom_range(9))
      0: begin
        p.red_in   = 8'(lvl);
        p.green_in = 8'(lvl);
        p.blue_in  = 8'(lvl);
      end
      1: begin
        p.red_in   = 8'(lvl);
        p.green_in = 8'(lvl);
      end
      2: begin
        p.green_in = 8'(lvl);
        p.blue_in  = 8'(lvl);
      end
      3: begin
        p.red_in   = 8'(lvl);
        p.blue_in  = 8'(lvl);
      end
      4, 5: begin
        // Channels within two steps of each other.
        lvl = $urandom_range(253);
        p.red_in   = 8'(lvl + $urandom_range(2));
        p.green_in = 8'(lvl + $urandom_range(2));
        p.blue_in  = 8'(lvl + $urandom_range(2));
      end
      6: begin
        p.red_in   = edge_chan();
        p.green_in = edge_chan();
        p.blue_in  = edge_chan();
        p.alpha_in = edge_chan();
      end
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    int idle_pct;
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_pixel <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: black, white and grey, the primaries and secondaries
    // (yellow, cyan and magenta exercise the tie order for the maximum),
    // red as maximum with green above and below blue, hue near the wrap,
    // single-step deltas and the alpha extremes.
    send_rgba(8'd0,   8'd0,   8'd0,   8'd0);
    send_rgba(8'd255, 8'd255, 8'd255, 8'd255);
    send_rgba(8'd128, 8'd128, 8'd128, 8'd77);
    send_rgba(8'd255, 8'd0,   8'd0,   8'd255);
    idle_for(3);
    send_rgba(8'd0,   8'd255, 8'd0,   8'd0);
    send_rgba(8'd0,   8'd0,   8'd255, 8'd170);
    send_rgba(8'd255, 8'd255, 8'd0,   8'd85);
    send_rgba(8'd0,   8'd255, 8'd255, 8'd255);
    send_rgba(8'd255, 8'd0,   8'd255, 8'd0);
    idle_for(1);
    send_rgba(8'd200, 8'd100, 8'd50,  8'd1);
    send_rgba(8'd200, 8'd50,  8'd100, 8'd254);
    send_rgba(8'd255, 8'd0,   8'd1,   8'd128);
    send_rgba(8'd10,  8'd200, 8'd30,  8'd127);
    send_rgba(8'd30,  8'd200, 8'd10,  8'd64);
    idle_for(8);
    send_rgba(8'd40,  8'd90,  8'd250, 8'd32);
    send_rgba(8'd90,  8'd40,  8'd250, 8'd16);
    send_rgba(8'd1,   8'd0,   8'd0,   8'd8);
    send_rgba(8'd0,   8'd0,   8'd1,   8'd4);
    send_rgba(8'd0,   8'd1,   8'd0,   8'd2);
    send_rgba(8'd255, 8'd254, 8'd254, 8'd255);
    send_rgba(8'd254, 8'd255, 8'd255, 8'd0);
    send_rgba(8'd255, 8'd254, 8'd255, 8'd170);
    send_rgba(8'd1,   8'd1,   8'd0,   8'd85);

    // Random words. The idle rate changes every fifty words so that some
    // stretches are dense and others sparse, and the tail runs at full rate.
    idle_pct = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 40;
        endcase
        if (i >= RANDOM_ITEMS - NO_IDLE_TAIL) begin
          idle_pct = 0;
        end
      end
      send_pixel(random_pixel());
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        idle_for($urandom_range(1, 8));
      end
    end
    start <= 1'b0;

    // Wait for every prediction to be consumed, then watch a while longer
    // for stray result words. The watchdog bounds both waits.
    while (hsv_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (hsv_sb.errors == 0 && hsv_sb.pending() == 0) begin
      $display("rgb_to_hsv_converter verification clean");
    end else begin
      $display("rgb_to_hsv_converter verification failed");
    end
    $finish;
  end

endmodule
